@@ sv/joint_velocity_clamped_p_step_macros.svh @@
// Assertion helpers, clocked on clk_i with reset rst_ni
`ifndef JOINT_VELOCITY_CLAMPED_P_STEP_MACROS_SVH
`define JOINT_VELOCITY_CLAMPED_P_STEP_MACROS_SVH

// same-cycle implication
`define JVC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define JVC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/jvc_pkg.sv @@
`timescale 1ns / 1ps
package jvc_pkg;

  localparam int unsigned NUM_JOINTS_DEF = 7;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned VEL_W          = 32;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_FEEDBACK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN  = 3'd0,
    CFG_LIMIT = 3'd1,
    CFG_TOL   = 3'd2,
    CFG_DT    = 3'd3,
    CFG_AGAIN = 3'd4
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] GAIN_RST  = 16'd256;
  localparam logic [CFG_W-1:0] LIMIT_RST = 16'd4096;
  localparam logic [CFG_W-1:0] TOL_RST   = 16'd41;
  localparam logic [CFG_W-1:0] DT_RST    = 16'd655;
  localparam logic [CFG_W-1:0] AGAIN_RST = 16'd256;

  typedef struct packed {
    logic capture;
    logic div_init;
    logic div_step;
    logic vel_load;
    logic mul_dt;
    logic mul_a;
  } lane_ctrl_t;

  typedef struct packed {
    logic clear;
    logic acc;
    logic sqrt_start;
    logic sqrt_step;
    logic clamp_eval;
  } merge_ctrl_t;

  // magnitude times 16-bit factor, rounded to nearest, ties away from zero
  function automatic logic [VEL_W-1:0] mul_round16(input logic [VEL_W-1:0] mag,
                                                   input logic [CFG_W-1:0] fac);
    logic [VEL_W+CFG_W-1:0] prod;
    prod = mag * fac;
    prod = prod + (VEL_W+CFG_W)'(32'h8000);
    return prod[VEL_W+CFG_W-1:16];
  endfunction

endpackage

@@ sv/jvc_lane.sv @@
`timescale 1ns / 1ps
module jvc_lane import jvc_pkg::*; #(
  parameter int unsigned RootW = 26
) (
  input  logic                    clk_i,
  input  lane_ctrl_t              ctrl_i,
  input  logic                    clamp_i,
  input  logic signed [POS_W-1:0] tgt_i,
  input  logic signed [POS_W-1:0] fbk_i,
  input  logic [CFG_W-1:0]        gain_i,
  input  logic [CFG_W-1:0]        limit_i,
  input  logic [CFG_W-1:0]        dt_i,
  input  logic [CFG_W-1:0]        again_i,
  input  logic [RootW-1:0]        enorm_i,
  output logic [2*POS_W-1:0]      sq_o,
  output logic signed [POS_W-1:0] fbk_o,
  output logic signed [POS_W-1:0] cmd_o
);

  logic signed [POS_W-1:0] fbk_q;
  logic                    neg_q;
  logic [POS_W-1:0]        mag_q;
  logic [2*POS_W-1:0]      sq_q;
  logic [RootW-1:0]        rem_q;
  logic [VEL_W-1:0]        dsh_q, quo_q, vmag_q, pmag_q, dmag_q;

  logic signed [POS_W:0]   err;
  logic [POS_W:0]          err_abs;
  logic [2*CFG_W-1:0]      prod;
  logic [RootW:0]          rt, ediv;
  logic                    ge;
  logic [2*CFG_W-1:0]      vel;
  logic signed [VEL_W+1:0] dsig, csum;

  assign err     = {tgt_i[POS_W-1], tgt_i} - {fbk_i[POS_W-1], fbk_i};
  assign err_abs = err[POS_W] ? (POS_W+1)'(-err) : err;
  assign prod    = mag_q * limit_i;
  assign rt      = {rem_q, dsh_q[VEL_W-1]};
  assign ediv    = {1'b0, enorm_i};
  assign ge      = rt >= ediv;
  assign vel     = mag_q * gain_i;
  assign dsig    = neg_q ? -$signed({2'b00, dmag_q}) : $signed({2'b00, dmag_q});
  assign csum    = $signed({{(VEL_W+2-POS_W){fbk_q[POS_W-1]}}, fbk_q}) + dsig;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      fbk_q <= fbk_i;
      neg_q <= err[POS_W];
      mag_q <= err_abs[POS_W-1:0];
      sq_q  <= err_abs[POS_W-1:0] * err_abs[POS_W-1:0];
    end
    if (ctrl_i.div_init) begin
      rem_q <= RootW'(prod[2*CFG_W-1:CFG_W]);
      dsh_q <= {prod[CFG_W-1:0], {CFG_W{1'b0}}};
      quo_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= ge ? RootW'(rt - ediv) : rt[RootW-1:0];
      dsh_q <= {dsh_q[VEL_W-2:0], 1'b0};
      quo_q <= {quo_q[VEL_W-2:0], ge};
    end
    if (ctrl_i.vel_load) vmag_q <= clamp_i ? quo_q : vel;
    if (ctrl_i.mul_dt)   pmag_q <= mul_round16(vmag_q, dt_i);
    if (ctrl_i.mul_a)    dmag_q <= mul_round16(pmag_q, again_i);
  end

  always_comb begin
    if (csum > $signed((VEL_W+2)'(32767)))       cmd_o = 16'sh7fff;
    else if (csum < -$signed((VEL_W+2)'(32768))) cmd_o = 16'sh8000;
    else                                         cmd_o = csum[POS_W-1:0];
  end

  assign sq_o  = sq_q;
  assign fbk_o = fbk_q;

endmodule

@@ sv/jvc_merge.sv @@
`timescale 1ns / 1ps
module jvc_merge import jvc_pkg::*; #(
  parameter int unsigned NumJoints = NUM_JOINTS_DEF,
  parameter int unsigned IdxW      = 3,
  parameter int unsigned SumW      = 35,
  parameter int unsigned RadW      = 52,
  parameter int unsigned RootW     = 26
) (
  input  logic               clk_i,
  input  merge_ctrl_t        ctrl_i,
  input  logic [IdxW-1:0]    idx_i,
  input  logic [2*POS_W-1:0] sq_i [NumJoints],
  input  logic [CFG_W-1:0]   tol_i,
  input  logic [CFG_W-1:0]   gain_i,
  input  logic [CFG_W-1:0]   limit_i,
  output logic [RootW-1:0]   enorm_o,
  output logic               reached_o,
  output logic               clamp_o
);

  logic [SumW-1:0]    sum_q;
  logic [RadW-1:0]    rad_q;
  logic [RootW+1:0]   rem_q;
  logic [RootW-1:0]   root_q;
  logic               clamp_q;

  logic [RootW+1:0]   rt, trial;
  logic               ge;
  logic [2*CFG_W-1:0] tol_sq;
  logic [CFG_W+RootW-1:0] kexp;

  assign rt     = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rt >= trial;
  assign tol_sq = tol_i * tol_i;
  assign kexp   = gain_i * root_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) sum_q <= '0;
    else if (ctrl_i.acc) sum_q <= sum_q + SumW'(sq_i[idx_i]);
    if (ctrl_i.sqrt_start) begin
      rad_q  <= RadW'({sum_q, 16'h0000});
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.sqrt_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? rt - trial : rt;
      root_q <= {root_q[RootW-2:0], ge};
    end
    if (ctrl_i.clamp_eval)
      clamp_q <= kexp > (CFG_W+RootW)'({limit_i, 16'h0000});
  end

  assign enorm_o   = root_q;
  assign reached_o = sum_q < SumW'(tol_sq);
  assign clamp_o   = clamp_q;

endmodule

@@ sv/joint_velocity_clamped_p_step.sv @@
`timescale 1ns / 1ps
// Joint position controller: a load beat (tuser 0) stores one target per joint and
// returns nothing; a feedback beat (tuser 1) returns one beat of commanded positions
// with the reached flag in tuser. One lane per joint forms the error, its square, a
// 32-step clamp divider and two rounding multiplies; a shared merge unit adds the
// squares one lane per cycle and takes a 26-step square root. A feedback beat that is
// already reached skips the square root, the clamp check, the divider and the multiplies;
// without the clamp the divider takes no steps. Input is taken again once the result sits
// in the output register. Configuration writes are taken every cycle.
module joint_velocity_clamped_p_step import jvc_pkg::*; #(
  parameter int unsigned NumJoints = NUM_JOINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [NumJoints*POS_W-1:0] s_axis_tdata,  // pos_0, pos_1, ... upward
  input  logic                       s_axis_tuser,  // command
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [NumJoints*POS_W-1:0] m_axis_tdata,  // cmd_0, cmd_1, ... upward
  output logic                       m_axis_tuser,  // reached
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  localparam int unsigned SumW     = 2*POS_W + $clog2(NumJoints);
  localparam int unsigned RadW     = 2*((SumW + 17)/2);
  localparam int unsigned RootW    = RadW/2;
  localparam int unsigned IdxW     = (NumJoints > 1) ? $clog2(NumJoints) : 1;
  localparam int unsigned MaxSteps = (RootW > VEL_W) ? RootW : VEL_W;
  localparam int unsigned CntW     = $clog2(MaxSteps + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_CHK, ST_SQRT, ST_CLAMP, ST_DIV, ST_VEL, ST_MDT, ST_MA, ST_DONE
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         cnt_q;
  logic                    reached_q;
  logic                    m_valid_q;
  logic [NumJoints*POS_W-1:0] m_data_q;
  logic                    m_user_q;
  logic signed [POS_W-1:0] tgt_q [NumJoints];
  logic [CFG_W-1:0]        gain_q, limit_q, tol_q, dt_q, again_q;

  lane_ctrl_t              lctrl;
  merge_ctrl_t             mctrl;
  logic                    in_fire, out_free;
  logic [2*POS_W-1:0]      sq [NumJoints];
  logic signed [POS_W-1:0] fbk [NumJoints];
  logic signed [POS_W-1:0] cmd [NumJoints];
  logic [RootW-1:0]        enorm;
  logic                    reached, clamp;
  logic [NumJoints*POS_W-1:0] res_data;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    lctrl = '0;
    mctrl = '0;
    unique case (state_q)
      ST_IDLE: begin
        lctrl.capture = in_fire && (s_axis_tuser == CMD_FEEDBACK);
        mctrl.clear   = lctrl.capture;
      end
      ST_ACC:   mctrl.acc = 1'b1;
      ST_CHK: begin
        lctrl.div_init   = 1'b1;
        mctrl.sqrt_start = 1'b1;
      end
      ST_SQRT:  mctrl.sqrt_step = 1'b1;
      ST_CLAMP: mctrl.clamp_eval = 1'b1;
      ST_DIV:   lctrl.div_step = clamp;
      ST_VEL:   lctrl.vel_load = 1'b1;
      ST_MDT:   lctrl.mul_dt = 1'b1;
      ST_MA:    lctrl.mul_a = 1'b1;
      default: ;
    endcase
  end

  for (genvar g = 0; g < NumJoints; g++) begin : g_lane
    jvc_lane #(.RootW(RootW)) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lctrl),
      .clamp_i (clamp),
      .tgt_i   (tgt_q[g]),
      .fbk_i   (s_axis_tdata[g*POS_W +: POS_W]),
      .gain_i  (gain_q),
      .limit_i (limit_q),
      .dt_i    (dt_q),
      .again_i (again_q),
      .enorm_i (enorm),
      .sq_o    (sq[g]),
      .fbk_o   (fbk[g]),
      .cmd_o   (cmd[g])
    );
    assign res_data[g*POS_W +: POS_W] = reached_q ? fbk[g] : cmd[g];
  end

  jvc_merge #(
    .NumJoints (NumJoints),
    .IdxW      (IdxW),
    .SumW      (SumW),
    .RadW      (RadW),
    .RootW     (RootW)
  ) u_merge (
    .clk_i     (clk_i),
    .ctrl_i    (mctrl),
    .idx_i     (cnt_q[IdxW-1:0]),
    .sq_i      (sq),
    .tol_i     (tol_q),
    .gain_i    (gain_q),
    .limit_i   (limit_q),
    .enorm_o   (enorm),
    .reached_o (reached),
    .clamp_o   (clamp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      reached_q <= 1'b0;
      m_valid_q <= 1'b0;
      m_user_q  <= 1'b0;
      m_data_q  <= '0;
      gain_q    <= GAIN_RST;
      limit_q   <= LIMIT_RST;
      tol_q     <= TOL_RST;
      dt_q      <= DT_RST;
      again_q   <= AGAIN_RST;
      for (int i = 0; i < NumJoints; i++) tgt_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GAIN:  gain_q  <= cfg_data_i;
          CFG_LIMIT: limit_q <= cfg_data_i;
          CFG_TOL:   tol_q   <= cfg_data_i;
          CFG_DT:    dt_q    <= cfg_data_i;
          CFG_AGAIN: again_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == CMD_LOAD) begin
              for (int i = 0; i < NumJoints; i++)
                tgt_q[i] <= s_axis_tdata[i*POS_W +: POS_W];
            end else begin
              cnt_q   <= '0;
              state_q <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(NumJoints - 1)) state_q <= ST_CHK;
        end
        ST_CHK: begin
          reached_q <= reached;
          cnt_q     <= '0;
          state_q   <= reached ? ST_DONE : ST_SQRT;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(RootW - 1)) state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (!clamp || cnt_q == CntW'(VEL_W - 1)) state_q <= ST_VEL;
        end
        ST_VEL: state_q <= ST_MDT;
        ST_MDT: state_q <= ST_MA;
        ST_MA:  state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_data;
            m_user_q  <= reached_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`include "joint_velocity_clamped_p_step_macros.svh"

  `JVC_ASSERT_NXT(a_load_no_work, in_fire && (s_axis_tuser == CMD_LOAD), state_q == ST_IDLE)
  `JVC_ASSERT_NXT(a_fbk_starts, in_fire && (s_axis_tuser == CMD_FEEDBACK), state_q == ST_ACC)
  `JVC_ASSERT_NXT(a_done_emits, (state_q == ST_DONE) && out_free, m_axis_tvalid)
  `JVC_ASSERT_IMP(a_reach_skips, (state_q == ST_VEL), !reached_q)

endmodule

@@ tb/sv/joint_velocity_clamped_p_step_tb.sv @@
`timescale 1ns / 1ps
module joint_velocity_clamped_p_step_tb;
  import jvc_pkg::*;

  localparam int NJ = NUM_JOINTS_DEF;
  localparam int DW = NJ * POS_W;

  typedef struct {
    logic [DW-1:0] pos;
    logic          reached;
  } command_beat_t;

  class command_scoreboard;
    logic signed [POS_W-1:0] targets[NJ];
    logic [CFG_W-1:0] gain, limit, tol, dt, again;
    command_beat_t pending[$];
    int errors;
    int checked;
    int reached_seen;
    int clamped_seen;

    function void reset_state();
      foreach (targets[i]) targets[i] = '0;
      gain = GAIN_RST;
      limit = LIMIT_RST;
      tol = TOL_RST;
      dt = DT_RST;
      again = AGAIN_RST;
      pending.delete();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_GAIN:  gain = v;
        CFG_LIMIT: limit = v;
        CFG_TOL:   tol = v;
        CFG_DT:    dt = v;
        CFG_AGAIN: again = v;
        default: ;
      endcase
    endfunction

    function longint round_q16(longint x);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m + 64'sh8000) >>> 16;
      return (x < 0) ? -m : m;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_input(logic cmd, logic [DW-1:0] data);
      longint e[NJ];
      longint fb[NJ];
      longint unsigned sum, enorm, q, mg;
      longint vel, p, d, c;
      bit clamp;
      command_beat_t exp_beat;
      sum = 0;
      if (cmd == CMD_LOAD) begin
        for (int i = 0; i < NJ; i++) targets[i] = data[i*POS_W +: POS_W];
        return;
      end
      for (int i = 0; i < NJ; i++) begin
        fb[i] = longint'($signed(data[i*POS_W +: POS_W]));
        e[i] = longint'(targets[i]) - fb[i];
        sum += longint'(e[i] * e[i]);
      end
      exp_beat.pos = data;
      exp_beat.reached = 1'b1;
      if (sum < longint'(tol) * longint'(tol)) begin
        pending.push_back(exp_beat);
        return;
      end
      enorm = int_sqrt(sum << 16);
      clamp = longint'(gain) * enorm > (longint'(limit) << 16);
      if (clamp) clamped_seen++;
      for (int i = 0; i < NJ; i++) begin
        if (clamp) begin
          mg = (e[i] < 0) ? -e[i] : e[i];
          q = ((mg * limit) << 16) / enorm;
          vel = (e[i] < 0) ? -longint'(q) : longint'(q);
        end else begin
          vel = e[i] * longint'(gain);
        end
        p = round_q16(vel * longint'(dt));
        d = round_q16(p * longint'(again));
        c = fb[i] + d;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        exp_beat.pos[i*POS_W +: POS_W] = c[POS_W-1:0];
      end
      exp_beat.reached = 1'b0;
      pending.push_back(exp_beat);
    endfunction

    function void check_output(logic [DW-1:0] data, logic reached);
      command_beat_t e;
      bit bad;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: data=%h reached=%b", data, reached);
        return;
      end
      e = pending.pop_front();
      bad = (reached !== e.reached);
      for (int i = 0; i < NJ; i++)
        if (data[i*POS_W +: POS_W] !== e.pos[i*POS_W +: POS_W]) bad = 1;
      if (reached) reached_seen++;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp data=%h reached=%b got data=%h reached=%b",
                   e.pos, e.reached, data, reached);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  command_scoreboard sb;
  bit quiet;
  int hold_cycles;
  int sent;

  joint_velocity_clamped_p_step u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int gap;
    gap = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic cmd, logic [DW-1:0] data);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, data);
    sent++;
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return POS_W'($urandom_range(0, 255));
      3: return POS_W'(-$urandom_range(0, 255));
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_vec();
    logic [DW-1:0] v;
    for (int i = 0; i < NJ; i++) v[i*POS_W +: POS_W] = rand_pos();
    return v;
  endfunction

  function automatic logic [DW-1:0] near_vec(logic [DW-1:0] base, int spread);
    logic [DW-1:0] v;
    for (int i = 0; i < NJ; i++)
      v[i*POS_W +: POS_W] = POS_W'(base[i*POS_W +: POS_W] + $urandom_range(0, 2*spread)
                                   - spread);
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return CFG_W'($urandom_range(1, 1024));
      default: return CFG_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [DW-1:0] tgt;
    sb = new();
    sb.reset_state();
    quiet = 0;
    hold_cycles = 0;
    sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, extremes, reached, clamp
    send_beat(CMD_FEEDBACK, '0);
    send_beat(CMD_FEEDBACK, {NJ{16'h7FFF}});
    send_beat(CMD_FEEDBACK, {NJ{16'h8000}});
    send_beat(CMD_LOAD, {NJ{16'h7FFF}});
    send_beat(CMD_FEEDBACK, {NJ{16'h8000}});
    send_beat(CMD_FEEDBACK, {NJ{16'h7FFF}});
    send_beat(CMD_FEEDBACK, {NJ{16'h7FF0}});
    send_beat(CMD_LOAD, {NJ{16'h8000}});
    send_beat(CMD_FEEDBACK, {NJ{16'h7FFF}});
    send_beat(CMD_FEEDBACK, {NJ{16'h5555}});
    send_beat(CMD_FEEDBACK, {NJ{16'hAAAA}});
    go_idle();
    write_reg(CFG_GAIN, 16'h0000);
    write_reg(CFG_TOL, 16'h0000);
    send_beat(CMD_FEEDBACK, {NJ{16'h8000}});
    send_beat(CMD_FEEDBACK, {NJ{16'h8000}});
    go_idle();
    write_reg(CFG_GAIN, 16'hFFFF);
    write_reg(CFG_LIMIT, 16'h0000);
    write_reg(CFG_DT, 16'hFFFF);
    write_reg(CFG_AGAIN, 16'hFFFF);
    send_beat(CMD_FEEDBACK, {NJ{16'h0000}});
    send_beat(CMD_FEEDBACK, {NJ{16'h7FFF}});
    go_idle();
    write_reg(CFG_LIMIT, 16'hFFFF);
    write_reg(CFG_TOL, 16'hFFFF);
    send_beat(CMD_FEEDBACK, {NJ{16'h0000}});
    send_beat(CMD_FEEDBACK, {NJ{16'h8100}});
    go_idle();

    // random phases with fresh settings
    for (int ph = 0; ph < 19; ph++) begin
      write_reg(CFG_GAIN, rand_cfg());
      write_reg(CFG_LIMIT, rand_cfg());
      write_reg(CFG_TOL, ($urandom_range(0, 1)) ? rand_cfg() :
                         CFG_W'($urandom_range(0, 300)));
      write_reg(CFG_DT, rand_cfg());
      write_reg(CFG_AGAIN, rand_cfg());
      quiet = (ph >= 17);
      if (ph == 3) hold_cycles = 2000;
      tgt = rand_vec();
      send_beat(CMD_LOAD, tgt);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 15) == 0) begin
          tgt = rand_vec();
          send_beat(CMD_LOAD, tgt);
        end else begin
          case ($urandom_range(0, 3))
            0: send_beat(CMD_FEEDBACK, near_vec(tgt, 8));
            1: send_beat(CMD_FEEDBACK, near_vec(tgt, 400));
            default: send_beat(CMD_FEEDBACK, rand_vec());
          endcase
        end
      end
      go_idle();
    end

    $display("Sent %0d beats, checked %0d results (%0d reached, %0d clamped).",
             sent, sb.checked, sb.reached_seen, sb.clamped_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
